// ----- rtl/core/tiq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiq_pkg
// Shared types and codes for the timed input queue.
// ----------------------------------------------------------------------------
package tiq_pkg;

  localparam logic [1:0] CMD_PUSH    = 2'd0;
  localparam logic [1:0] CMD_CONSUME = 2'd1;
  localparam logic [1:0] CMD_QUERY   = 2'd2;
  localparam logic [1:0] CMD_CLEAR   = 2'd3;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_NONE     = 3'd1;
  localparam logic [2:0] ST_REPEAT   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam int          CFG_INDEX_W  = 4;
  localparam logic [3:0]  REG_HOLD     = 4'd0;
  localparam logic [3:0]  REG_SPAM_GAP = 4'd1;
  localparam logic [15:0] HOLD_RESET   = 16'd300;
  localparam logic [15:0] SPAM_RESET   = 16'd100;

  localparam logic [3:0]  KIND_NONE    = 4'd0;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  kind;
    logic [31:0] now_ticks;
    logic [15:0] window_ticks;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       found;
    logic [3:0] kind_out;
    logic [4:0] fill;
  } rsp_item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] stamp;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH_RD,
    S_PUSH_CHK,
    S_SCAN,
    S_FINISH
  } state_t;

endpackage

// ----- rtl/core/timed_input_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_input_queue
// Push: a read state, then a check state unless kind is none or the queue is
// empty. Clear goes straight to finish. Consume: scans n entries from the
// front (n <= fill). Query: front stale scan plus newest-first scan.
// One entry is read per cycle while scanning.
// Next command is accepted at the edge after the response goes valid.
// Reset clears pointers, count and handshake state; RAM is not cleared.
// ----------------------------------------------------------------------------
module timed_input_queue #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_stall,
  input  tiq_pkg::cmd_item_t                cmd_item,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output tiq_pkg::rsp_item_t                rsp_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tiq_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [15:0]                       cfg_data
);

  import tiq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW:0]   DEPTH_W = (CW + 1)'(DEPTH);

  state_t          state, state_next;
  cmd_item_t       cur;
  logic [AW-1:0]   head;
  logic [CW-1:0]   count;
  logic [CW-1:0]   idx;
  logic            pend;
  logic            phase;     // query: 0 = stale scan from front, 1 = newest-first scan
  logic [15:0]     hold_ticks;
  logic [15:0]     spam_gap_ticks;
  logic [2:0]      res_status;
  logic            res_found;
  logic [3:0]      res_kind;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   mem_raddr;
  logic [35:0]     mem_rdata;
  entry_t          rd_entry;
  entry_t          wr_entry;
  logic [CW-1:0]   rd_pos;

  logic [31:0]     age;
  logic            fresh;
  logic            in_window;
  logic            kind_match;
  logic            is_repeat;
  logic            accept;
  logic            rsp_free;

  logic            scan_fin;
  logic            scan_switch;
  logic            scan_issue;
  logic            do_drop;
  logic [CW-1:0]   drop_n;
  logic [2:0]      sc_status;
  logic            sc_found;
  logic [3:0]      sc_kind;
  logic            push_write;
  logic [CW+4:0]   fill_ext;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] pos);
    logic [CW:0] sum;
    sum = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, pos};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  tiq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (wr_entry),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_entry   = entry_t'(mem_rdata);
  assign age        = cur.now_ticks - rd_entry.stamp;
  assign fresh      = age <= {16'd0, hold_ticks};
  assign in_window  = age <= {16'd0, cur.window_ticks};
  assign kind_match = rd_entry.kind == cur.kind;
  assign is_repeat  = kind_match && (age < {16'd0, spam_gap_ticks});
  assign accept     = cmd_valid && !cmd_stall;
  assign rsp_free   = !rsp_valid || !rsp_stall;
  assign cfg_ready  = 1'b1;
  assign fill_ext   = {5'd0, count};

  // Scan step: check the entry read last cycle, then decide to stop or read on.
  always_comb begin
    scan_fin    = 1'b0;
    scan_switch = 1'b0;
    scan_issue  = 1'b0;
    do_drop     = 1'b0;
    drop_n      = count;
    sc_status   = ST_NOTFOUND;
    sc_found    = 1'b0;
    sc_kind     = KIND_NONE;
    if (pend && cur.command == CMD_CONSUME && fresh) begin
      scan_fin  = 1'b1;
      do_drop   = 1'b1;
      drop_n    = idx;
      sc_status = ST_DONE;
      sc_found  = 1'b1;
      sc_kind   = rd_entry.kind;
    end else if (pend && cur.command == CMD_QUERY && !phase && fresh) begin
      scan_switch = 1'b1;
      do_drop     = 1'b1;
      drop_n      = idx - CW'(1);
    end else if (pend && cur.command == CMD_QUERY && phase && !in_window) begin
      scan_fin = 1'b1;
    end else if (pend && cur.command == CMD_QUERY && phase && kind_match) begin
      scan_fin  = 1'b1;
      sc_status = ST_DONE;
      sc_found  = 1'b1;
    end else if (idx == count) begin
      scan_fin = 1'b1;
      do_drop  = !phase;
    end else begin
      scan_issue = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd_item.command == CMD_PUSH) begin
            state_next = S_PUSH_RD;
          end else if (cmd_item.command == CMD_CLEAR) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_PUSH_RD: begin
        if (cur.kind == KIND_NONE || count == '0) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_PUSH_CHK;
        end
      end
      S_PUSH_CHK: state_next = S_FINISH;
      S_SCAN: begin
        if (scan_fin) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_stall     = state != S_IDLE;
    push_write    = 1'b0;
    rd_pos        = idx;
    wr_entry.kind  = cur.kind;
    wr_entry.stamp = cur.now_ticks;
    unique case (state)
      S_PUSH_RD: begin
        push_write = cur.kind != KIND_NONE && count == '0;
        rd_pos     = count - CW'(1);
      end
      S_PUSH_CHK: push_write = !is_repeat && count != DEPTH_C;
      S_SCAN: begin
        if (phase) begin
          rd_pos = count - idx - CW'(1);
        end
      end
      default: rd_pos = idx;
    endcase
    mem_we    = push_write;
    mem_waddr = slot_of(head, count);
    mem_raddr = slot_of(head, rd_pos);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      head           <= '0;
      count          <= '0;
      idx            <= '0;
      pend           <= 1'b0;
      phase          <= 1'b0;
      rsp_valid      <= 1'b0;
      hold_ticks     <= HOLD_RESET;
      spam_gap_ticks <= SPAM_RESET;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_HOLD) begin
          hold_ticks <= cfg_data;
        end else if (cfg_index == REG_SPAM_GAP) begin
          spam_gap_ticks <= cfg_data;
        end
      end

      if (state == S_FINISH && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            cur        <= cmd_item;
            idx        <= '0;
            pend       <= 1'b0;
            phase      <= 1'b0;
            res_status <= ST_DONE;
            res_found  <= 1'b0;
            res_kind   <= KIND_NONE;
            if (cmd_item.command == CMD_CLEAR) begin
              count <= '0;
              head  <= '0;
            end
          end
        end
        S_PUSH_RD: begin
          if (cur.kind == KIND_NONE) begin
            res_status <= ST_NONE;
          end else if (push_write) begin
            count <= count + CW'(1);
          end
        end
        S_PUSH_CHK: begin
          if (is_repeat) begin
            res_status <= ST_REPEAT;
          end else if (count == DEPTH_C) begin
            res_status <= ST_FULL;
          end else begin
            count <= count + CW'(1);
          end
        end
        S_SCAN: begin
          if (do_drop) begin
            if (drop_n >= count) begin
              count <= '0;
              head  <= '0;
            end else begin
              head  <= slot_of(head, drop_n);
              count <= count - drop_n;
            end
          end
          if (scan_fin) begin
            res_status <= sc_status;
            res_found  <= sc_found;
            res_kind   <= sc_kind;
          end
          if (scan_switch) begin
            phase <= 1'b1;
            idx   <= '0;
            pend  <= 1'b0;
          end else if (scan_issue) begin
            idx  <= idx + CW'(1);
            pend <= 1'b1;
          end
        end
        S_FINISH: begin
          if (rsp_free) begin
            rsp_item.status   <= res_status;
            rsp_item.found    <= res_found;
            rsp_item.kind_out <= res_kind;
            rsp_item.fill     <= fill_ext[4:0];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/tiq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tiq_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- dv/timed_input_queue_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_input_queue_test
// Self-checking bench for the timed input queue. A scoreboard keeps its own
// copy of the queue and the two timing registers and predicts the response
// of every accepted command. Responses are compared field by field in
// order. Stimulus is a directed opening followed by phases of random
// command streams under several register settings, with random valid gaps,
// random response stalls, one long response hold-off and drains between
// phases.
// ----------------------------------------------------------------------------
module timed_input_queue_test;
  import tiq_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 125;
  localparam int LONG_HOLD    = 300;

  class tiq_scoreboard;
    logic [3:0]  kinds  [QUEUE_DEPTH];
    logic [31:0] stamps [QUEUE_DEPTH];
    int unsigned head;
    int unsigned count;
    logic [15:0] hold;
    logic [15:0] gap;
    rsp_item_t   expected_rsp[$];
    int          errors;

    function new();
      head   = 0;
      count  = 0;
      hold   = HOLD_RESET;
      gap    = SPAM_RESET;
      errors = 0;
    endfunction

    function int unsigned slot(int unsigned i);
      return (head + i) % QUEUE_DEPTH;
    endfunction

    function logic [31:0] age(int unsigned i, logic [31:0] now);
      return now - stamps[slot(i)];
    endfunction

    function void drop_front(int unsigned n);
      if (n >= count) begin
        count = 0;
        head  = 0;
      end else begin
        head  = slot(n);
        count = count - n;
      end
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] index, logic [15:0] data);
      if (index == REG_HOLD) hold = data;
      else if (index == REG_SPAM_GAP) gap = data;
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    function void note_command(cmd_item_t c);
      rsp_item_t   r;
      int unsigned i;
      int unsigned n;
      r = '0;
      r.status = ST_DONE;
      case (c.command)
        CMD_PUSH: begin
          if (c.kind == KIND_NONE) begin
            r.status = ST_NONE;
          end else if (count > 0 && kinds[slot(count - 1)] == c.kind &&
                       age(count - 1, c.now_ticks) < gap) begin
            r.status = ST_REPEAT;
          end else if (count >= QUEUE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            kinds[slot(count)]  = c.kind;
            stamps[slot(count)] = c.now_ticks;
            count++;
          end
        end
        CMD_CONSUME: begin
          r.status = ST_NOTFOUND;
          for (i = 0; i < count; i++) begin
            if (age(i, c.now_ticks) <= hold) begin
              r.kind_out = kinds[slot(i)];
              r.found    = 1'b1;
              r.status   = ST_DONE;
              break;
            end
          end
          if (r.found) drop_front(i + 1);
          else drop_front(count);
        end
        CMD_QUERY: begin
          n = 0;
          while (n < count && age(n, c.now_ticks) > hold) n++;
          drop_front(n);
          r.status = ST_NOTFOUND;
          // newest first, stop at the first entry outside the window
          for (i = count; i > 0; i--) begin
            if (age(i - 1, c.now_ticks) > c.window_ticks) break;
            if (kinds[slot(i - 1)] == c.kind) begin
              r.found  = 1'b1;
              r.status = ST_DONE;
              break;
            end
          end
        end
        default: drop_front(count);
      endcase
      r.fill = 5'(count);
      expected_rsp.push_back(r);
    endfunction

    function void check_response(rsp_item_t got);
      rsp_item_t want;
      if (expected_rsp.size() == 0) begin
        $error("unexpected response transaction: status %0d found %0d kind_out %0d fill %0d",
               got.status, got.found, got.kind_out, got.fill);
        errors++;
        return;
      end
      want = expected_rsp.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, got.found);
        errors++;
      end
      if (got.kind_out !== want.kind_out) begin
        $error("kind_out: expected %0d, actual %0d", want.kind_out, got.kind_out);
        errors++;
      end
      if (got.fill !== want.fill) begin
        $error("fill: expected %0d, actual %0d", want.fill, got.fill);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cmd_valid;
  logic                   cmd_stall;
  cmd_item_t              cmd_item;
  logic                   rsp_valid;
  logic                   rsp_stall;
  rsp_item_t              rsp_item;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [15:0]            cfg_data;

  tiq_scoreboard sb;
  logic [31:0]   tick_now;
  bit            burst_mode;
  bit            long_hold_req;

  timed_input_queue #(.DEPTH(QUEUE_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp_item);
  end

  // response side: random stalls, quiet stretches, one long hold-off on request
  initial begin
    int n;
    rsp_stall = 1'b0;
    forever begin
      if (long_hold_req) begin
        rsp_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        rsp_stall <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
        rsp_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // holds the transaction until accepted, then maybe idles the command side
  task automatic send_command(cmd_item_t c);
    int r;
    int n;
    cmd_valid <= 1'b1;
    cmd_item  <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sb.note_command(c);
    r = $urandom_range(0, 19);
    if (burst_mode || r < 10) n = 0;
    else if (r < 18) n = $urandom_range(1, 3);
    else n = $urandom_range(20, 100);
    if (n > 0) begin
      cmd_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic issue(logic [1:0] op, logic [3:0] kind, logic [31:0] now,
                       logic [15:0] window);
    cmd_item_t c;
    c.command      = op;
    c.kind         = kind;
    c.now_ticks    = now;
    c.window_ticks = window;
    send_command(c);
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(index, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic advance_time();
    case ($urandom_range(0, 15))
      0, 1, 2, 3:                 tick_now = tick_now;
      4, 5, 6, 7, 8, 9, 10:       tick_now += $urandom_range(0, sb.hold / 4 + 3);
      11, 12, 13:                 tick_now += $urandom_range(0, sb.hold + sb.gap + 50);
      default:                    tick_now += $urandom_range(0, 2000);
    endcase
  endtask

  task automatic make_random(output cmd_item_t c);
    int r;
    advance_time();
    c.now_ticks    = tick_now;
    c.window_ticks = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                          : 16'($urandom_range(0, 400));
    c.kind         = 4'($urandom_range(0, 15));
    r = $urandom_range(0, 99);
    if (r < 50) begin
      c.command = CMD_PUSH;
      if (r < 3) c.kind = KIND_NONE;
      else if (r < 16 && sb.count > 0) c.kind = sb.kinds[sb.slot(sb.count - 1)];
      else c.kind = 4'($urandom_range(1, 15));
    end else if (r < 70) begin
      c.command = CMD_CONSUME;
    end else if (r < 95) begin
      c.command = CMD_QUERY;
      if (r < 90 && sb.count > 0)
        c.kind = sb.kinds[sb.slot($urandom_range(0, sb.count - 1))];
    end else begin
      c.command = CMD_CLEAR;
    end
  endtask

  initial begin
    cmd_item_t   c;
    logic [15:0] hold_val;
    logic [15:0] gap_val;
    int          p;
    int          k;
    int          i;
    sb            = new();
    rst           = 1'b1;
    cmd_valid     = 1'b0;
    cmd_item      = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    tick_now      = '0;
    burst_mode    = 1'b0;
    long_hold_req = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed opening, reset register values
    issue(CMD_PUSH, KIND_NONE, 32'd0, 16'd0);
    issue(CMD_CONSUME, KIND_NONE, 32'd0, 16'd0);
    issue(CMD_QUERY, 4'd5, 32'd0, 16'hFFFF);
    issue(CMD_PUSH, 4'd15, 32'd0, 16'd0);
    issue(CMD_PUSH, 4'd15, 32'd5, 16'd0);          // fast repeat
    for (i = 0; i < QUEUE_DEPTH - 1; i++)
      issue(CMD_PUSH, 4'((i % 14) + 1), 32'(10 + i), 16'hFFFF);
    issue(CMD_PUSH, 4'd3, 32'd30, 16'd0);          // queue full
    issue(CMD_QUERY, KIND_NONE, 32'd30, 16'hFFFF);
    issue(CMD_QUERY, 4'd1, 32'd30, 16'd0);         // newest outside window
    issue(CMD_QUERY, 4'd1, 32'd30, 16'd6);
    issue(CMD_CONSUME, KIND_NONE, 32'd30, 16'd0);
    issue(CMD_CONSUME, KIND_NONE, 32'd400, 16'd0); // everything stale
    issue(CMD_PUSH, 4'd7, 32'hFFFF_FFF0, 16'd0);
    issue(CMD_QUERY, 4'd7, 32'h0000_0005, 16'hFFFF); // age across the wrap
    issue(CMD_CLEAR, KIND_NONE, 32'h0000_0005, 16'd0);
    tick_now = 32'h0000_0005;

    for (p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0:       begin hold_val = HOLD_RESET; gap_val = SPAM_RESET; end
        1:       begin hold_val = 16'd0;      gap_val = 16'd0;      end
        2:       begin hold_val = 16'hFFFF;   gap_val = 16'hFFFF;   end
        3:       begin hold_val = 16'd0;      gap_val = 16'hFFFF;   end
        4:       begin hold_val = 16'hFFFF;   gap_val = 16'd0;      end
        5:       begin
          hold_val = 16'($urandom_range(0, 1000));
          gap_val  = 16'($urandom_range(0, 300));
        end
        default: begin
          hold_val = 16'($urandom());
          gap_val  = 16'($urandom());
        end
      endcase
      if ($urandom_range(0, 1)) begin
        write_register(REG_HOLD, hold_val);
        write_register(REG_SPAM_GAP, gap_val);
      end else begin
        write_register(REG_SPAM_GAP, gap_val);
        write_register(REG_HOLD, hold_val);
      end
      // unmapped index, must be ignored
      if ($urandom_range(0, 1))
        write_register(CFG_INDEX_W'($urandom_range(2, 15)), 16'($urandom()));

      if (p == 2) tick_now = 32'hFFFF_FE00;
      else tick_now += $urandom();

      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) burst_mode = ($urandom_range(0, 2) == 0);
        if (p == 1 && k == 40) long_hold_req = 1'b1;
        if (k == 70 && $urandom_range(0, 1)) drain();
        make_random(c);
        send_command(c);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
